// ===== src/stunbr_pkg.sv =====
// Shared types, constants and helper functions for the STUN binding response parser.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package stunbr_pkg;

    localparam int unsigned MAX_DATAGRAM_DEF = 512;
    localparam int unsigned HEADER_BYTES     = 20;
    // Attribute offsets can run past the 16-bit length plus header, so keep headroom.
    localparam int unsigned ATTR_W           = 18;

    localparam logic [31:0] MAGIC_COOKIE = 32'h2112A442;
    localparam logic [15:0] TYPE_SUCCESS = 16'h0101;
    localparam logic [15:0] ATTR_XOR     = 16'h0020;
    localparam logic [15:0] ATTR_PLAIN   = 16'h0001;
    localparam logic [7:0]  FAMILY_V4    = 8'h01;

    localparam int unsigned CFG_DATA_W  = 64;
    localparam int unsigned CFG_INDEX_W = 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TXN_HEAD = 1'b0,
        CFG_TXN_TAIL = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_WRONG_SOURCE = 3'd2,
        ST_BAD_HEADER   = 3'd3,
        ST_OVERRUN      = 3'd4,
        ST_NO_ADDRESS   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       src;
    } in_item_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        status_t     status;
    } result_t;

    // Expected value of a fixed header byte; the length bytes (2 and 3) are not checked.
    function automatic logic [7:0] expected_byte(input logic [4:0] p,
                                                 input logic [63:0] head,
                                                 input logic [31:0] tail);
        logic [7:0] e;
        begin
            case (p)
                5'd0:    e = TYPE_SUCCESS[15:8];
                5'd1:    e = TYPE_SUCCESS[7:0];
                5'd4:    e = MAGIC_COOKIE[31:24];
                5'd5:    e = MAGIC_COOKIE[23:16];
                5'd6:    e = MAGIC_COOKIE[15:8];
                5'd7:    e = MAGIC_COOKIE[7:0];
                5'd8:    e = head[63:56];
                5'd9:    e = head[55:48];
                5'd10:   e = head[47:40];
                5'd11:   e = head[39:32];
                5'd12:   e = head[31:24];
                5'd13:   e = head[23:16];
                5'd14:   e = head[15:8];
                5'd15:   e = head[7:0];
                5'd16:   e = tail[31:24];
                5'd17:   e = tail[23:16];
                5'd18:   e = tail[15:8];
                5'd19:   e = tail[7:0];
                default: e = 8'h00;
            endcase
            return e;
        end
    endfunction

    function automatic logic [ATTR_W-1:0] round_up4(input logic [15:0] len);
        logic [ATTR_W-1:0] r;
        begin
            r = (ATTR_W'(len) + ATTR_W'(3)) & ~ATTR_W'(3);
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/stunbr_parser.sv =====
// Per-datagram state of the STUN binding response parser: header check and attribute walk.
// Depends on stunbr_pkg; instantiated by stun_binding_response_parser_unit.
`default_nettype none

module stunbr_parser #(
    parameter int unsigned MAX_DATAGRAM = stunbr_pkg::MAX_DATAGRAM_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire stunbr_pkg::in_item_t item,
    input  wire logic [63:0]        txn_head,
    input  wire logic [31:0]        txn_tail,
    output stunbr_pkg::result_t     result
);
    import stunbr_pkg::*;

    localparam int unsigned POS_W = $clog2(MAX_DATAGRAM + 1);

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic              src_ok;
        logic              hdr_bad;
        logic [15:0]       msg_len;
        logic [ATTR_W-1:0] next_start;
        logic [15:0]       atype;
        logic [15:0]       alen;
        logic              cand;
        logic              found;
        logic [15:0]       port;
        logic [31:0]       addr;
    } dgram_t;

    localparam dgram_t DGRAM_CLEAR = '{
        pos:        '0,
        src_ok:     1'b0,
        hdr_bad:    1'b0,
        msg_len:    16'h0000,
        next_start: ATTR_W'(HEADER_BYTES),
        atype:      16'h0000,
        alen:       16'h0000,
        cand:       1'b0,
        found:      1'b0,
        port:       16'h0000,
        addr:       32'h0000_0000
    };

    dgram_t            state_reg;
    dgram_t            state_next;
    dgram_t            upd;
    logic [ATTR_W-1:0] p_x;
    logic [ATTR_W-1:0] attr_end;
    logic [ATTR_W-1:0] attr_end_upd;
    logic [ATTR_W-1:0] s;
    logic [ATTR_W-1:0] v;

    always_comb
    begin
        upd      = state_reg;
        p_x      = ATTR_W'(state_reg.pos);
        attr_end = ATTR_W'(HEADER_BYTES) + ATTR_W'(state_reg.msg_len);
        s        = state_reg.next_start;
        v        = s + ATTR_W'(4);

        // Bytes past the size limit are dropped; only their end flag matters.
        if (state_reg.pos < POS_W'(MAX_DATAGRAM))
        begin
            upd.pos = state_reg.pos + POS_W'(1);
            if (p_x < ATTR_W'(HEADER_BYTES))
            begin
                if (state_reg.pos == '0)
                begin
                    upd.src_ok = item.src;
                end
                if (p_x == ATTR_W'(2) || p_x == ATTR_W'(3))
                begin
                    upd.msg_len = {state_reg.msg_len[7:0], item.data};
                end
                else if (item.data != expected_byte(state_reg.pos[4:0], txn_head, txn_tail))
                begin
                    upd.hdr_bad = 1'b1;
                end
            end
            else if (!state_reg.found)
            begin
                if (!state_reg.cand)
                begin
                    // Collect the four-byte attribute header if it lies inside the message.
                    if (v <= attr_end && p_x >= s && p_x < v)
                    begin
                        if (p_x < s + ATTR_W'(2))
                        begin
                            upd.atype = {state_reg.atype[7:0], item.data};
                        end
                        else
                        begin
                            upd.alen = {state_reg.alen[7:0], item.data};
                        end
                        if (p_x == s + ATTR_W'(3))
                        begin
                            if ((upd.atype == ATTR_XOR || upd.atype == ATTR_PLAIN) &&
                                upd.alen >= 16'd8 && v + ATTR_W'(upd.alen) <= attr_end)
                            begin
                                upd.cand = 1'b1;
                            end
                            else
                            begin
                                upd.next_start = v + round_up4(upd.alen);
                            end
                        end
                    end
                end
                else
                begin
                    if (p_x == v + ATTR_W'(1))
                    begin
                        if (item.data != FAMILY_V4)
                        begin
                            upd.cand       = 1'b0;
                            upd.next_start = v + round_up4(state_reg.alen);
                        end
                    end
                    else if (p_x == v + ATTR_W'(2) || p_x == v + ATTR_W'(3))
                    begin
                        upd.port = {state_reg.port[7:0], item.data};
                    end
                    else if (p_x >= v + ATTR_W'(4) && p_x <= v + ATTR_W'(7))
                    begin
                        upd.addr = {state_reg.addr[23:0], item.data};
                        if (p_x == v + ATTR_W'(7))
                        begin
                            if (state_reg.atype == ATTR_XOR)
                            begin
                                upd.port = state_reg.port ^ MAGIC_COOKIE[31:16];
                                upd.addr = {state_reg.addr[23:0], item.data} ^ MAGIC_COOKIE;
                            end
                            upd.found = 1'b1;
                        end
                    end
                end
            end
        end

        // Verdict from the state including this byte; earlier checks take priority.
        attr_end_upd = ATTR_W'(HEADER_BYTES) + ATTR_W'(upd.msg_len);
        result.port  = 16'h0000;
        result.addr  = 32'h0000_0000;
        if (ATTR_W'(upd.pos) < ATTR_W'(HEADER_BYTES))
        begin
            result.status = ST_TOO_SHORT;
        end
        else if (!upd.src_ok)
        begin
            result.status = ST_WRONG_SOURCE;
        end
        else if (upd.hdr_bad)
        begin
            result.status = ST_BAD_HEADER;
        end
        else if (attr_end_upd > ATTR_W'(upd.pos))
        begin
            result.status = ST_OVERRUN;
        end
        else if (!upd.found || upd.port == 16'h0000)
        begin
            result.status = ST_NO_ADDRESS;
        end
        else
        begin
            result.status = ST_OK;
            result.port   = upd.port;
            result.addr   = upd.addr;
        end

        state_next = item.last ? DGRAM_CLEAR : upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DGRAM_CLEAR;
        end
        else if (step)
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/stun_binding_response_parser_unit.sv =====
// Top level of the STUN binding response parser: stream ports, configuration and output register.
// Depends on stunbr_pkg and stunbr_parser.
//
// Feed a received UDP datagram one byte per transfer, tlast on its final byte and the
// source-match flag in tuser with the first byte. The block takes one byte every clock cycle
// unless a waiting result holds it; each byte is held in an input register, then folded into
// the datagram state by a single pass of compares against the running attribute offsets. One
// result transfer (status, port, IPv4 address) follows each datagram, via the input and then
// the output register; a waiting result stalls the input only when another datagram ends.
// Bytes beyond MAX_DATAGRAM are ignored except for their tlast. The user must write the expected
// transaction id through the configuration port while no datagram is in progress (not enforced).
`default_nettype none

module stun_binding_response_parser_unit #(
    parameter int unsigned MAX_DATAGRAM = stunbr_pkg::MAX_DATAGRAM_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [7:0]                         s_axis_tdata,  // data_byte
    input  wire logic                               s_axis_tlast,  // end_of_datagram
    input  wire logic                               s_axis_tuser,  // source_match
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // status [2:0], decoded port [18:3], decoded IPv4 address [50:19], zero fill [55:51]
    output logic [55:0]                             m_axis_tdata,
    input  wire logic                               cfg_we,
    input  wire logic [stunbr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [stunbr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import stunbr_pkg::*;

    logic [63:0] txn_head_reg;
    logic [31:0] txn_tail_reg;
    logic        in_valid_reg;
    in_item_t    in_item_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_reg;
    result_t     parse_result;
    logic        advance;
    logic        s_fire;

    // A byte that ends a datagram needs a free output register; other bytes always move on.
    assign advance       = in_valid_reg && (!in_item_reg.last || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && in_item_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    stunbr_parser #(
        .MAX_DATAGRAM (MAX_DATAGRAM)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .item     (in_item_reg),
        .txn_head (txn_head_reg),
        .txn_tail (txn_tail_reg),
        .result   (parse_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            txn_head_reg  <= 64'h0;
            txn_tail_reg  <= 32'h0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TXN_HEAD: txn_head_reg <= cfg_data[63:0];
                    CFG_TXN_TAIL: txn_tail_reg <= cfg_data[31:0];
                    default:      txn_tail_reg <= txn_tail_reg;
                endcase
            end
            if (s_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_item_reg <= '{data: s_axis_tdata, last: s_axis_tlast, src: s_axis_tuser};
        end
        if (advance && in_item_reg.last)
        begin
            out_reg <= parse_result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b00000, out_reg.addr, out_reg.port, out_reg.status};

endmodule

`default_nettype wire
